### rtl/core/fsc_pkg.sv
package fsc_pkg;

  // width_mode codes; the spare code runs as the 64-bit mode
  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;
  localparam logic [1:0] MODE_64 = 2'd2;

  localparam int MODE_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int SEED_W       = 64;
  localparam int SUM_W        = 32;
  localparam int GATHER_W     = 24;
  localparam int POS_W        = 2;
  localparam int IN_TDATA_W   = BYTE_W + SEED_W;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 64;

  // flag bits in in_tuser
  localparam int TUSER_HAS_BYTE = 0;
  localparam int TUSER_FIRST    = 1;

  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [GATHER_W-1:0] gather_t;
  typedef logic [POS_W-1:0]    pos_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              first;
    logic              last;
    logic [SEED_W-1:0] seed;
  } item_t;

endpackage

### rtl/core/fletcher_style_checksum.sv
// Fletcher-style checksum over a byte stream, one byte per item. width_mode
// picks a 16, 32 or 64 bit checksum (8, 16 or 32 bit sums, words of 1, 2 or
// 4 bytes gathered little-endian); both sums wrap modulo 2^8, 2^16 or 2^32.
// An item with the first flag loads the sums from its seed (sum2 high half,
// sum1 low half); the item with tlast flushes a zero-padded tail word and
// produces one result item, sum2 above sum1, upper bits zero. Items without
// a byte add nothing, so an empty buffer returns the seed. Throughput is one
// item per clock: an input register feeds one add pair (sum1, then sum2)
// that writes the sum registers and the result register. The result is
// registered as its last item leaves the input register. A last item waits
// there only while the result register is full and not being taken; other
// items never wait. Write width_mode only while the block is idle.
module fletcher_style_checksum (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fsc_pkg::MODE_W-1:0]         cfg_data,    // width_mode
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fsc_pkg::IN_TDATA_W-1:0]     in_tdata,    // data_byte[7:0], seed[71:8]
  input  logic [fsc_pkg::IN_TUSER_W-1:0]     in_tuser,    // has_byte[0], first[1]
  input  logic                               in_tlast,    // last
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fsc_pkg::OUT_TDATA_W-1:0]    out_tdata    // checksum[63:0]
);
  import fsc_pkg::*;

  logic [MODE_W-1:0] mode_r;

  // input register
  logic  s1_valid_r;
  item_t s1_r;

  // running state
  sum_t    low_r, high_r;
  gather_t gather_r;
  pos_t    pos_r;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic adv;

  // mode decode
  sum_t mask;
  sum_t seed_high;
  logic word_done;

  // item datapath
  sum_t    low_base, high_base;
  gather_t gather_base;
  pos_t    pos_base;
  sum_t    word;
  gather_t gather_after;
  pos_t    pos_after;
  logic    do_add;
  sum_t    add_word;
  sum_t    sum1, sum2;
  sum_t    low_nxt, high_nxt;
  gather_t gather_nxt;
  pos_t    pos_nxt;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign cfg_ready = 1'b1;

  // a last item needs the result register; everything else goes straight on
  assign adv       = s1_valid_r && (!s1_r.last || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign low_base    = s1_r.first ? (s1_r.seed[SUM_W-1:0] & mask) : (low_r & mask);
  assign high_base   = s1_r.first ? seed_high : (high_r & mask);
  assign gather_base = s1_r.first ? '0 : gather_r;
  assign pos_base    = s1_r.first ? '0 : pos_r;

  always_comb begin
    unique case (mode_r)
      MODE_16: begin
        mask      = 32'h0000_00FF;
        seed_high = {24'h0, s1_r.seed[15:8]};
        word_done = 1'b1;
      end
      MODE_32: begin
        mask      = 32'h0000_FFFF;
        seed_high = {16'h0, s1_r.seed[31:16]};
        word_done = (pos_base != '0);
      end
      default: begin
        mask      = 32'hFFFF_FFFF;
        seed_high = s1_r.seed[63:32];
        word_done = (pos_base == 2'd3);
      end
    endcase
  end

  always_comb begin
    word = {8'h0, gather_base} | ({24'h0, s1_r.data_byte} << {pos_base, 3'b000});

    if (s1_r.has_byte && !word_done) begin
      gather_after = word[GATHER_W-1:0];
      pos_after    = pos_base + 2'd1;
    end else if (s1_r.has_byte) begin
      gather_after = '0;
      pos_after    = '0;
    end else begin
      gather_after = gather_base;
      pos_after    = pos_base;
    end

    // at most one word per item: a completed word, or the tail flush on last
    do_add   = (s1_r.has_byte && word_done) || (s1_r.last && pos_after != '0);
    add_word = (s1_r.has_byte && word_done) ? word : {8'h0, gather_after};

    sum1 = (low_base + (add_word & mask)) & mask;
    sum2 = (high_base + sum1) & mask;

    low_nxt  = do_add ? sum1 : low_base;
    high_nxt = do_add ? sum2 : high_base;

    gather_nxt = s1_r.last ? '0 : gather_after;
    pos_nxt    = s1_r.last ? '0 : pos_after;

    unique case (mode_r)
      MODE_16: out_data_nxt = {48'h0, high_nxt[7:0], low_nxt[7:0]};
      MODE_32: out_data_nxt = {32'h0, high_nxt[15:0], low_nxt[15:0]};
      default: out_data_nxt = {high_nxt, low_nxt};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_16;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      low_r       <= '0;
      high_r      <= '0;
      gather_r    <= '0;
      pos_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        low_r    <= low_nxt;
        high_r   <= high_nxt;
        gather_r <= gather_nxt;
        pos_r    <= pos_nxt;
      end
      if (adv && s1_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r.data_byte <= in_tdata[BYTE_W-1:0];
      s1_r.seed      <= in_tdata[IN_TDATA_W-1:BYTE_W];
      s1_r.has_byte  <= in_tuser[TUSER_HAS_BYTE];
      s1_r.first     <= in_tuser[TUSER_FIRST];
      s1_r.last      <= in_tlast;
    end
    if (adv && s1_r.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a held item stays in the input register until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("input register dropped a stalled item");

  // a new result only follows a last item leaving the input register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_r.last))
    else $error("result without a last item");

  // the tail is always flushed on last
  a_tail_clr: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_r.last |=> pos_r == '0 && gather_r == '0)
    else $error("gather state not cleared after last item");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fsc_pkg::*;

  // mode code with no name in the package; the block runs it as 64-bit
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_PHASE   = 3;    // receiver stalls for a long stretch here
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 6;    // result is registered as its last item leaves the input register
  localparam int QUIET_LIMIT  = 2000; // cycles with no handshake at all

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [MODE_W-1:0]      cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // data_byte[7:0], seed[71:8]
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // has_byte[0], first[1]
  logic                   in_tlast = 1'b0; // last
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // checksum[63:0]

  fletcher_style_checksum u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // items waiting to be sent, and checksums waiting to come out
  item_t             tx_items[$];
  logic [63:0]       pending_sums[$];
  int                fail_cnt = 0;

  // knobs set by the stimulus process between phases
  bit                send_idle_on = 1'b0;
  bit                recv_idle_on = 1'b0;
  int                hold_req = 0;

  // predictor state: mode as last written, both sums, partial word
  logic [MODE_W-1:0] cur_mode;
  sum_t              sum_lo;
  sum_t              sum_hi;
  gather_t           gather_q;
  pos_t              pos_q;

  function automatic void add_word(input sum_t word, input sum_t msk);
    sum_lo = (sum_lo + (word & msk)) & msk;
    sum_hi = (sum_hi + sum_lo) & msk;
  endfunction

  // one accepted item; returns 1 with the checksum when the item closes a buffer
  function automatic bit checksum_step(input item_t it, output logic [63:0] chk);
    sum_t msk;
    int   half;
    int   wbytes;
    case (cur_mode)
      MODE_16: begin
        msk = 32'h0000_00FF; half = 8;  wbytes = 1;
      end
      MODE_32: begin
        msk = 32'h0000_FFFF; half = 16; wbytes = 2;
      end
      default: begin
        msk = 32'hFFFF_FFFF; half = 32; wbytes = 4;
      end
    endcase
    chk = '0;
    if (it.first) begin
      sum_lo   = sum_t'(it.seed) & msk;
      sum_hi   = sum_t'((it.seed >> half) & 64'(msk));
      gather_q = '0;
      pos_q    = '0;
    end
    // a mode change since the last item narrows the sums here
    sum_lo &= msk;
    sum_hi &= msk;
    if (it.has_byte) begin
      if (int'(pos_q) + 1 >= wbytes) begin
        add_word(sum_t'(gather_q) | (sum_t'(it.data_byte) << (8 * pos_q)), msk);
        gather_q = '0;
        pos_q    = '0;
      end else begin
        gather_q = gather_q | (gather_t'(it.data_byte) << (8 * pos_q));
        pos_q    = pos_q + 1'b1;
      end
    end
    if (it.last) begin
      // zero-padded tail word
      if (pos_q != '0) add_word(sum_t'(gather_q), msk);
      gather_q = '0;
      pos_q    = '0;
      chk = (64'(sum_hi) << half) | 64'(sum_lo);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // sender: presents the head of tx_items, drops it once taken
  always @(posedge clk) begin : tx_drive
    int                    tx_gap;
    logic [IN_TUSER_W-1:0] flags;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) tx_items.delete(0);
      if (in_tvalid && !in_tready) begin
        // item still on offer: hold it
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(0, 11);
        in_tvalid <= 1'b0;
      end else if (tx_items.size() != 0) begin
        flags                 = '0;
        flags[TUSER_HAS_BYTE] = tx_items[0].has_byte;
        flags[TUSER_FIRST]    = tx_items[0].first;
        in_tdata  <= {tx_items[0].seed, tx_items[0].data_byte};
        in_tuser  <= flags;
        in_tlast  <= tx_items[0].last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready: random stall bursts, plus a long hold on request
  always @(posedge clk) begin : rx_ready
    int rx_gap;
    int hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap    = 0;
      hold_done = 0;
    end else if (hold_done != hold_req) begin
      hold_done++;
      rx_gap = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // input side: track mode writes and run the predictor on each taken item
  always @(posedge clk) begin : in_mon
    item_t       it;
    logic [63:0] chk;
    if (!rst_n) begin
      cur_mode = MODE_16;
      sum_lo   = '0;
      sum_hi   = '0;
      gather_q = '0;
      pos_q    = '0;
    end else begin
      if (cfg_valid && cfg_ready) cur_mode = cfg_data;
      if (in_tvalid && in_tready) begin
        it.data_byte = in_tdata[BYTE_W-1:0];
        it.seed      = in_tdata[BYTE_W +: SEED_W];
        it.has_byte  = in_tuser[TUSER_HAS_BYTE];
        it.first     = in_tuser[TUSER_FIRST];
        it.last      = in_tlast;
        if (checksum_step(it, chk)) pending_sums.push_back(chk);
      end
    end
  end

  // output side: each result against the oldest predicted checksum
  always @(posedge clk) begin : out_mon
    logic [63:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $error("checksum: expected none, got %h", out_tdata);
        fail_cnt++;
      end else begin
        want = pending_sums.pop_front();
        if (out_tdata !== want) begin
          $error("checksum: expected %h, got %h", want, out_tdata);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
          || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_item(input logic [7:0] b, input bit has, input bit fst,
                           input bit lst, input logic [63:0] sd);
    item_t it;
    it.data_byte = b;
    it.has_byte  = has;
    it.first     = fst;
    it.last      = lst;
    it.seed      = sd;
    tx_items.push_back(it);
  endtask

  // everything sent, every result back, then a settle wait for a taken
  // item without last that may still be in the input register
  task automatic wait_idle();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_tvalid || pending_sums.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    @(posedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    int          n;
    int          len;
    int          kind;
    logic [1:0]  m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    write_mode(MODE_16);
    @(negedge clk);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    // empty buffer on one item: the seed comes back, cut to 16 bits
    push_item(8'hA5, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(8'h00, 1, 1, 0, 64'h0);
    push_item(8'hFF, 1, 0, 0, 64'h0);
    push_item(8'hFF, 1, 0, 1, 64'h0);
    // carries on from the previous sums, no first
    push_item(8'h80, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(8'h7F, 0, 0, 1, 64'h0);
    wait_idle();

    write_mode(MODE_32);
    @(negedge clk);
    // odd byte count: one-byte tail word
    push_item(8'h01, 1, 1, 0, 64'h0123_4567_89AB_CDEF);
    push_item(8'h02, 1, 0, 0, 64'h0);
    push_item(8'hFF, 1, 0, 1, 64'h0);
    push_item(8'hFF, 1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    write_mode(MODE_64);
    @(negedge clk);
    push_item(8'h11, 1, 1, 0, 64'hFEDC_BA98_7654_3210);
    push_item(8'h22, 1, 0, 0, 64'h0);
    push_item(8'h33, 1, 0, 0, 64'h0);
    push_item(8'h44, 1, 0, 0, 64'h0);
    push_item(8'h55, 1, 0, 1, 64'h0);
    // three-byte tail under all-ones sums
    push_item(8'hFF, 1, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(8'hFF, 1, 0, 0, 64'h0);
    push_item(8'hFF, 1, 0, 1, 64'h0);
    wait_idle();

    write_mode(MODE_SPARE);
    @(negedge clk);
    push_item(8'h01, 1, 1, 0, 64'h0);
    push_item(8'h02, 1, 0, 0, 64'h0);
    push_item(8'h03, 1, 0, 1, 64'h0);
    // leave a partial word open, then narrow the mode under it
    push_item(8'hAB, 1, 1, 0, 64'h8000_0001_8000_0001);
    wait_idle();

    write_mode(MODE_16);
    @(negedge clk);
    push_item(8'hCD, 1, 0, 0, 64'h0);
    push_item(8'hEF, 1, 0, 1, 64'h0);
    wait_idle();

    // ---- random part ----
    for (int ph = 0; ph < PHASES; ph++) begin
      m = 2'($urandom_range(0, 3));
      write_mode(m);
      @(negedge clk);
      send_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      recv_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // sender keeps going so that the block backs up behind the result
        send_idle_on = 1'b0;
        hold_req++;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = $urandom_range(0, 19);
        if (ph == HOLD_PHASE)
          len = $urandom_range(1, 3);
        else if ($urandom_range(0, 7) == 0)
          len = $urandom_range(13, 40);
        else
          len = $urandom_range(1, 12);
        // kind 0: no first, continues from the last sums
        // kind 1: stray restarts inside the buffer
        for (int i = 0; i < len; i++)
          push_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
                    (i == 0 && kind != 0) || (kind == 1 && $urandom_range(0, 5) == 0),
                    i == len - 1, {$urandom, $urandom});
        n += len;
      end
      // every third phase leaves a buffer open across the mode write
      if (ph % 3 == 2) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          push_item(8'($urandom_range(0, 255)), 1, i == 0, 0, {$urandom, $urandom});
      end
      wait_idle();
    end

    // close whatever buffer is still open
    push_item(8'($urandom_range(0, 255)), 1, 0, 1, 64'h0);
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
